// ===== src/coprime_pair_enumerator_core_macros.svh =====
// Assertion macros for the coprime pair enumerator.
// Used by files under src that carry concurrent checks; no other dependency.
`ifndef COPRIME_PAIR_ENUMERATOR_CORE_MACROS_SVH
`define COPRIME_PAIR_ENUMERATOR_CORE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CPE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check an implication on every rising clock edge outside reset.
`define CPE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/cpe_pkg.sv =====
// Shared types and constants of the coprime pair enumerator.
// No dependencies; used by the interfaces and the core.
`default_nettype none

package cpe_pkg;

    localparam int CAPACITY  = 2048;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 2);
    localparam int VAL_W     = 14;
    localparam int OP_W      = 2;
    localparam int ST_W      = 3;
    localparam logic [VAL_W-1:0] VALUE_MAX = VAL_W'(10000);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_NEXT  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_FULL    = 3'd2,
        ST_DONE    = 3'd3,
        ST_CLEARED = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DUP_RD,
        S_DUP_CMP,
        S_WALK,
        S_RD_I,
        S_RD_J,
        S_LD_GCD,
        S_GCD,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== src/cpe_if.sv =====
// Valid/ready channels of the coprime pair enumerator.
// Depends on cpe_pkg for field widths.
`default_nettype none

interface cpe_req_if;
    logic                         valid;
    logic                         ready;
    logic [cpe_pkg::OP_W-1:0]     opcode;
    logic [cpe_pkg::VAL_W-1:0]    value;
    modport source (output valid, opcode, value, input ready);
    modport sink   (input valid, opcode, value, output ready);
endinterface

interface cpe_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [cpe_pkg::ST_W-1:0]     status;
    logic [cpe_pkg::VAL_W-1:0]    first_value;
    logic [cpe_pkg::VAL_W-1:0]    second_value;
    modport source (output valid, status, first_value, second_value, input ready);
    modport sink   (input valid, status, first_value, second_value, output ready);
endinterface

`default_nettype wire

// ===== src/coprime_pair_enumerator_core.sv =====
// Coprime pair enumerator: value store, duplicate scan and pair walk.
// Depends on cpe_pkg, cpe_if.sv and coprime_pair_enumerator_core_macros.svh.
//
//  channel  | dir | word fields
//  ---------+-----+----------------------------------------
//  i_req    | in  | opcode, value
//  o_rsp    | out | status, first_value, second_value
//
// One word at a time. Clear and unused opcode go from accept straight to the output state.
// Load: the duplicate scan reads and compares each stored entry through the single store
// read port, then the value is written if new and not full. Next: per candidate pair, the
// walk, two store reads and the gcd load, then one binary gcd step per cycle; a finished row moves the cursors on.
// Reset is synchronous and clears counts and cursors; the store needs none.
// A finished word waits in the output register while the next request runs.
`default_nettype none
`include "coprime_pair_enumerator_core_macros.svh"

module coprime_pair_enumerator_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cpe_req_if.sink    i_req,
    cpe_rsp_if.source  o_rsp
);

    localparam int IW = cpe_pkg::IDX_W;
    localparam int CW = cpe_pkg::CNT_W;
    localparam int VW = cpe_pkg::VAL_W;

    // store memory
    logic [VW-1:0] mem [cpe_pkg::CAPACITY];

    cpe_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_oc, n_oc, r_ic, n_ic;
    logic [CW-1:0]    r_i, n_i, r_j, n_j, r_k, n_k;
    logic [VW-1:0]    r_v, n_v;
    logic             r_dup, n_dup;
    logic [VW-1:0]    r_va, n_va, r_vb, n_vb, r_ga, n_ga, r_gb, n_gb;
    logic [VW-1:0]    r_rdata;
    cpe_pkg::t_status r_rst, n_rst;
    logic [VW-1:0]    r_rf, n_rf, r_rs, n_rs;
    logic             r_ov;
    logic [cpe_pkg::ST_W-1:0] r_ost;
    logic [VW-1:0]    r_of, r_os;

    logic             w_we, w_re, w_load_out;
    logic [IW-1:0]    w_raddr;
    logic [VW-1:0]    w_clamp;

    assign i_req.ready        = (r_state == cpe_pkg::S_IDLE);
    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_ost;
    assign o_rsp.first_value  = r_of;
    assign o_rsp.second_value = r_os;

    // clamp load value into range
    always_comb begin
        if (i_req.value == '0) begin
            w_clamp = VW'(1);
        end else if (i_req.value > cpe_pkg::VALUE_MAX) begin
            w_clamp = cpe_pkg::VALUE_MAX;
        end else begin
            w_clamp = i_req.value;
        end
    end

    // next state and datapath
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_oc = r_oc;
        n_ic = r_ic;
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        n_v = r_v;
        n_dup = r_dup;
        n_va = r_va;
        n_vb = r_vb;
        n_ga = r_ga;
        n_gb = r_gb;
        n_rst = r_rst;
        n_rf = r_rf;
        n_rs = r_rs;
        w_we = 1'b0;
        w_re = 1'b0;
        w_raddr = r_k[IW-1:0];
        w_load_out = 1'b0;
        unique case (r_state)
            cpe_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_rst = cpe_pkg::ST_OK;
                    n_rf = '0;
                    n_rs = '0;
                    n_state = cpe_pkg::S_OUT;
                    unique case (cpe_pkg::t_opcode'(i_req.opcode))
                        cpe_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_oc = '0;
                            n_ic = CW'(1);
                            n_rst = cpe_pkg::ST_CLEARED;
                        end
                        cpe_pkg::OP_LOAD: begin
                            n_oc = '0;
                            n_ic = CW'(1);
                            n_v = w_clamp;
                            n_k = '0;
                            n_dup = 1'b0;
                            n_state = cpe_pkg::S_DUP_RD;
                        end
                        cpe_pkg::OP_NEXT: begin
                            n_i = r_oc;
                            n_j = r_ic;
                            n_state = cpe_pkg::S_WALK;
                        end
                        default: begin
                            n_state = cpe_pkg::S_OUT;
                        end
                    endcase
                end
            end
            // scan stored entries: read one, then compare it
            cpe_pkg::S_DUP_RD: begin
                if (r_k >= r_count) begin
                    n_state = cpe_pkg::S_OUT;
                    if (r_dup) begin
                        n_rst = cpe_pkg::ST_DUP;
                    end else if (r_count >= CW'(cpe_pkg::CAPACITY)) begin
                        n_rst = cpe_pkg::ST_FULL;
                    end else begin
                        w_we = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end else begin
                    w_re = 1'b1;
                    w_raddr = r_k[IW-1:0];
                    n_state = cpe_pkg::S_DUP_CMP;
                end
            end
            cpe_pkg::S_DUP_CMP: begin
                if (r_rdata == r_v) begin
                    n_dup = 1'b1;
                end
                n_k = r_k + CW'(1);
                n_state = cpe_pkg::S_DUP_RD;
            end
            // advance the pair cursors
            cpe_pkg::S_WALK: begin
                if (r_i >= r_count) begin
                    n_oc = r_count;
                    n_ic = r_count + CW'(1);
                    n_rst = cpe_pkg::ST_DONE;
                    n_state = cpe_pkg::S_OUT;
                end else if (r_j >= r_count) begin
                    n_i = r_i + CW'(1);
                    n_j = r_i + CW'(2);
                end else begin
                    n_state = cpe_pkg::S_RD_I;
                end
            end
            cpe_pkg::S_RD_I: begin
                w_re = 1'b1;
                w_raddr = r_i[IW-1:0];
                n_state = cpe_pkg::S_RD_J;
            end
            cpe_pkg::S_RD_J: begin
                w_re = 1'b1;
                w_raddr = r_j[IW-1:0];
                n_va = r_rdata;
                n_state = cpe_pkg::S_LD_GCD;
            end
            cpe_pkg::S_LD_GCD: begin
                n_vb = r_rdata;
                n_ga = r_va;
                n_gb = r_rdata;
                n_state = cpe_pkg::S_GCD;
            end
            // binary gcd, one step per cycle
            cpe_pkg::S_GCD: begin
                if ((r_ga == r_gb) || (!r_ga[0] && !r_gb[0])) begin
                    if (r_ga == VW'(1) && r_gb == VW'(1)) begin
                        n_oc = r_i;
                        n_ic = r_j + CW'(1);
                        n_rst = cpe_pkg::ST_OK;
                        n_rf = r_va;
                        n_rs = r_vb;
                        n_state = cpe_pkg::S_OUT;
                    end else begin
                        n_j = r_j + CW'(1);
                        n_state = cpe_pkg::S_WALK;
                    end
                end else if (!r_ga[0]) begin
                    n_ga = r_ga >> 1;
                end else if (!r_gb[0]) begin
                    n_gb = r_gb >> 1;
                end else if (r_ga > r_gb) begin
                    n_ga = r_ga - r_gb;
                end else begin
                    n_gb = r_gb - r_ga;
                end
            end
            // hand the word to the output register
            cpe_pkg::S_OUT: begin
                if (!r_ov || o_rsp.ready) begin
                    w_load_out = 1'b1;
                    n_state = cpe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cpe_pkg::S_IDLE;
            end
        endcase
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_count[IW-1:0]] <= r_v;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpe_pkg::S_IDLE;
            r_count <= '0;
            r_oc <= '0;
            r_ic <= CW'(1);
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_oc <= n_oc;
            r_ic <= n_ic;
            if (w_load_out) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_j <= n_j;
        r_k <= n_k;
        r_v <= n_v;
        r_dup <= n_dup;
        r_va <= n_va;
        r_vb <= n_vb;
        r_ga <= n_ga;
        r_gb <= n_gb;
        r_rst <= n_rst;
        r_rf <= n_rf;
        r_rs <= n_rs;
        if (w_load_out) begin
            r_ost <= r_rst;
            r_of <= r_rf;
            r_os <= r_rs;
        end
    end

    `CPE_ASSERT(a_count_cap, r_count <= CW'(cpe_pkg::CAPACITY), "store count over capacity")
    `CPE_ASSERT_IMPL(a_gcd_nonzero, r_state == cpe_pkg::S_GCD,
        r_ga != '0 && r_gb != '0, "gcd operand reached zero")
    `CPE_ASSERT_IMPL(a_pair_both, o_rsp.valid && o_rsp.first_value != '0,
        o_rsp.second_value != '0 && o_rsp.status == cpe_pkg::ST_OK, "partial pair word")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench of the coprime pair enumerator core: directed words, then random words.
// Depends on cpe_pkg, cpe_if.sv and the core; a local predictor gives the expected responses.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

    localparam int VW  = cpe_pkg::VAL_W;
    localparam int CAP = cpe_pkg::CAPACITY;

    typedef struct {
        cpe_pkg::t_status status;
        logic [VW-1:0]    first_value;
        logic [VW-1:0]    second_value;
    } t_pair_rsp;

    localparam int STALL_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;

    cpe_req_if req_ch ();
    cpe_rsp_if rsp_ch ();

    coprime_pair_enumerator_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Predictor state
    logic [VW-1:0] stored_vals [CAP];
    int            stored_cnt;
    int            walk_i;
    int            walk_j;

    t_pair_rsp pending_rsp[$];
    int        fail_cnt;
    bit        idle_on;
    int        hold_cycles;
    int        quiet_cycles;

    // Clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int euclid_gcd(int a, int b);
        int r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // Advance the predictor by one request word
    function automatic t_pair_rsp predict_pair(cpe_pkg::t_opcode op, logic [VW-1:0] val);
        t_pair_rsp r;
        int        v;
        bit        dup;
        r.status       = cpe_pkg::ST_OK;
        r.first_value  = '0;
        r.second_value = '0;
        case (op)
            cpe_pkg::OP_CLEAR: begin
                stored_cnt = 0;
                walk_i     = 0;
                walk_j     = 1;
                r.status   = cpe_pkg::ST_CLEARED;
            end
            cpe_pkg::OP_LOAD: begin
                v   = (val == 0) ? 1 : ((val > 10000) ? 10000 : int'(val));
                dup = 1'b0;
                for (int k = 0; k < stored_cnt; k++)
                    if (int'(stored_vals[k]) == v) dup = 1'b1;
                walk_i = 0;
                walk_j = 1;
                if (dup) begin
                    r.status = cpe_pkg::ST_DUP;
                end else if (stored_cnt >= CAP) begin
                    r.status = cpe_pkg::ST_FULL;
                end else begin
                    stored_vals[stored_cnt] = VW'(v);
                    stored_cnt++;
                end
            end
            cpe_pkg::OP_NEXT: begin
                while (walk_i < stored_cnt) begin
                    if (walk_j >= stored_cnt) begin
                        walk_i++;
                        walk_j = walk_i + 1;
                    end else if (euclid_gcd(int'(stored_vals[walk_i]),
                                            int'(stored_vals[walk_j])) == 1) begin
                        r.first_value  = stored_vals[walk_i];
                        r.second_value = stored_vals[walk_j];
                        walk_j++;
                        return r;
                    end else begin
                        walk_j++;
                    end
                end
                walk_i   = stored_cnt;
                walk_j   = stored_cnt + 1;
                r.status = cpe_pkg::ST_DONE;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offer one word, hold it until accepted, then record its expected response
    task automatic send_word(cpe_pkg::t_opcode op, logic [VW-1:0] val);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.opcode = op;
        req_ch.value  = val;
        req_ch.valid  = 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_rsp.push_back(predict_pair(op, val));
        @(negedge i_clk);
    endtask

    task automatic drain_responses();
        req_ch.valid = 1'b0;
        wait (pending_rsp.size() == 0);
        @(negedge i_clk);
    endtask

    // Response side readiness: random bursts of stall, or a long counted hold
    initial begin
        rsp_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                rsp_ch.ready = 1'b0;
                hold_cycles--;
                @(negedge i_clk);
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end else begin
                rsp_ch.ready = 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // Compare each response word with the oldest expectation
    always @(posedge i_clk) begin
        t_pair_rsp e;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                $error("response word with no expectation");
                fail_cnt++;
            end else begin
                e = pending_rsp.pop_front();
                if (rsp_ch.status !== e.status) begin
                    $error("status expected %0d got %0d", e.status, rsp_ch.status);
                    fail_cnt++;
                end
                if (rsp_ch.first_value !== e.first_value) begin
                    $error("first_value expected %0d got %0d", e.first_value,
                           rsp_ch.first_value);
                    fail_cnt++;
                end
                if (rsp_ch.second_value !== e.second_value) begin
                    $error("second_value expected %0d got %0d", e.second_value,
                           rsp_ch.second_value);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_empty_store();
        send_word(cpe_pkg::OP_NEXT, '0);
        send_word(cpe_pkg::OP_NEXT, 14'h3FFF);
        send_word(cpe_pkg::OP_NONE, 14'h2AAA);
        send_word(cpe_pkg::OP_CLEAR, 14'h1555);
    endtask

    // Clamp of out-of-range values, duplicates of clamped values
    task automatic test_load_extremes();
        send_word(cpe_pkg::OP_LOAD, 14'd0);
        send_word(cpe_pkg::OP_LOAD, 14'd1);
        send_word(cpe_pkg::OP_LOAD, 14'd10000);
        send_word(cpe_pkg::OP_LOAD, 14'h3FFF);
        send_word(cpe_pkg::OP_LOAD, 14'd10001);
        send_word(cpe_pkg::OP_NEXT, '0);
        send_word(cpe_pkg::OP_NEXT, '0);
        send_word(cpe_pkg::OP_CLEAR, '0);
    endtask

    // Walk through a small store to exhaustion, then restart by a rejected load
    task automatic test_pair_walk();
        send_word(cpe_pkg::OP_LOAD, 14'd6);
        send_word(cpe_pkg::OP_LOAD, 14'd10);
        send_word(cpe_pkg::OP_LOAD, 14'd15);
        send_word(cpe_pkg::OP_LOAD, 14'd7);
        repeat (5) send_word(cpe_pkg::OP_NEXT, '0);
        send_word(cpe_pkg::OP_NEXT, '0);
        send_word(cpe_pkg::OP_LOAD, 14'd10);
        send_word(cpe_pkg::OP_NEXT, '0);
        send_word(cpe_pkg::OP_NONE, '0);
        send_word(cpe_pkg::OP_NEXT, '0);
        send_word(cpe_pkg::OP_CLEAR, '0);
    endtask

    // Hold the response side long while requests keep coming, then pause
    task automatic test_backpressure();
        hold_cycles = 400;
        for (int k = 0; k < 8; k++)
            send_word(cpe_pkg::OP_LOAD, VW'($urandom_range(1, 40)));
        drain_responses();
        send_word(cpe_pkg::OP_NEXT, '0);
        send_word(cpe_pkg::OP_CLEAR, '0);
    endtask

    function automatic logic [VW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VW'($urandom_range(0, 16383));
            1:       return VW'($urandom_range(9990, 10010));
            default: return VW'($urandom_range(1, 48));
        endcase
    endfunction

    // Mostly load and next on a small store, with clears and unused opcodes
    task automatic test_random_words(int count);
        int sel;
        for (int n = 0; n < count; n++) begin
            if (n > count - 40) idle_on = 1'b0;
            sel = $urandom_range(0, 99);
            if (stored_cnt >= 18 && sel < 50) sel = 0;
            if (sel < 4)
                send_word(cpe_pkg::OP_CLEAR, VW'($urandom_range(0, 16383)));
            else if (sel < 50)
                send_word(cpe_pkg::OP_LOAD, pick_value());
            else if (sel < 95)
                send_word(cpe_pkg::OP_NEXT, VW'($urandom_range(0, 16383)));
            else
                send_word(cpe_pkg::OP_NONE, VW'($urandom_range(0, 16383)));
        end
    endtask

    initial begin
        fail_cnt     = 0;
        idle_on      = 1'b1;
        hold_cycles  = 0;
        quiet_cycles = 0;
        stored_cnt   = 0;
        walk_i       = 0;
        walk_j       = 1;
        req_ch.valid  = 1'b0;
        req_ch.opcode = cpe_pkg::OP_NONE;
        req_ch.value  = '0;
        i_rst_n       = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_store();
        test_load_extremes();
        test_pair_walk();
        test_backpressure();
        test_random_words(250);

        drain_responses();
        repeat (100) @(negedge i_clk);
        if (fail_cnt == 0 && pending_rsp.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/cpe_pkg.sv
src/cpe_if.sv
src/coprime_pair_enumerator_core.sv
tb/testbench.sv
